/* src/plbu_pkg.sv */
// Package for the price level book update block: field widths, codes and the
// structs shared between the top level, the side rows and the level cells.
// Depends on nothing; every other file imports it.
package plbu_pkg;

  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 32;
  localparam int ID_W     = 48;
  localparam int LEVELS_W = 6;

  // Default number of levels held on each side of the book.
  localparam int PLBU_DEPTH = 32;

  // Message kind and book side codes.
  localparam logic KIND_SNAPSHOT = 1'b0;
  localparam logic KIND_DELTA    = 1'b1;
  localparam logic SIDE_BID      = 1'b0;
  localparam logic SIDE_ASK      = 1'b1;

  // Update id that never counts as a gap when it is the stored id.
  localparam logic [ID_W-1:0] ID_NO_GAP = ID_W'(1);

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

  // Per-cell update controls, at most one of them is set in a cycle.
  typedef struct packed {
    logic load;       // take the item's price and quantity
    logic set_qty;    // keep the price, take the item's quantity
    logic pull_next;  // take the level of the cell below (delete)
    logic pull_prev;  // take the level of the cell above (insert)
  } cell_ctrl_t;

  // Controls from the top level to one side row.
  typedef struct packed {
    logic capture;   // register the compare flags of all cells
    logic clear;     // empty the side at the start of a full replacement
    logic update;    // apply the held item to this side
    logic replaces;  // the current message is a full replacement
  } row_ctrl_t;

endpackage

/* src/plbu_in_if.sv */
// Input channel of the price level book update block: one price level a transfer.
// Depends on plbu_pkg.
interface plbu_in_if import plbu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic               book_side;
  logic [PRICE_W-1:0] price;
  logic [QTY_W-1:0]   quantity;
  logic [ID_W-1:0]    update_id;
  logic               last_of_message;

  modport source (
    output valid, kind, book_side, price, quantity, update_id, last_of_message,
    input  ready
  );
  modport sink (
    input  valid, kind, book_side, price, quantity, update_id, last_of_message,
    output ready
  );
endinterface

/* src/plbu_out_if.sv */
// Result channel of the price level book update block: top of book per message.
// Depends on plbu_pkg.
interface plbu_out_if import plbu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PRICE_W-1:0]  best_bid_price;
  logic [QTY_W-1:0]    best_bid_qty;
  logic [PRICE_W-1:0]  best_ask_price;
  logic [QTY_W-1:0]    best_ask_qty;
  logic [LEVELS_W-1:0] bid_levels;
  logic [LEVELS_W-1:0] ask_levels;
  logic [ID_W-1:0]     applied_id;
  logic                resynced;

  modport source (
    output valid, best_bid_price, best_bid_qty, best_ask_price, best_ask_qty,
           bid_levels, ask_levels, applied_id, resynced,
    input  ready
  );
  modport sink (
    input  valid, best_bid_price, best_bid_qty, best_ask_price, best_ask_qty,
           bid_levels, ask_levels, applied_id, resynced,
    output ready
  );
endinterface

/* src/plbu_cell.sv */
// One level cell of a book side: holds a price and quantity, compares them with
// the incoming price and takes a new level or a neighbour's. Depends on plbu_pkg.
module plbu_cell import plbu_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               valid,
  input  logic [PRICE_W-1:0] cmp_price,
  input  level_t             new_level,
  input  level_t             prev_level,
  input  level_t             next_level,
  output level_t             level,
  output level_t             level_nxt,
  output logic               eq,
  output logic               lt,
  output logic               gt
);

  level_t level_r;

  always_comb begin
    level_nxt = level_r;
    if (ctrl.load) begin
      level_nxt = new_level;
    end else if (ctrl.set_qty) begin
      level_nxt.qty = new_level.qty;
    end else if (ctrl.pull_next) begin
      level_nxt = next_level;
    end else if (ctrl.pull_prev) begin
      level_nxt = prev_level;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
  end

  assign level = level_r;
  assign eq    = valid && (cmp_price == level_r.price);
  assign lt    = valid && (cmp_price < level_r.price);
  assign gt    = valid && (cmp_price > level_r.price);

endmodule

/* src/plbu_row.sv */
// One side of the book: a row of level cells with its level count, turning
// the cells' compare flags into update, delete and insert controls.
// Depends on plbu_pkg and plbu_cell.
module plbu_row import plbu_pkg::*; #(
  parameter int DEPTH = PLBU_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               is_ask,
  input  row_ctrl_t          ctrl,
  input  logic [PRICE_W-1:0] cmp_price,
  input  level_t             item,
  output level_t             top_nxt,
  output logic [CNT_W-1:0]   cnt_nxt
);

  logic [CNT_W-1:0] cnt_r;
  logic [DEPTH-1:0] eq_v, lt_v, gt_v, valid_v;
  logic [DEPTH-1:0] match_r, beats_r;
  logic [DEPTH-1:0] m_first, b_first, tail, ins;
  logic [DEPTH-1:0] load_m, set_m, pull_next_m, pull_prev_m;
  logic             room, any_m, any_b;
  level_t           cur   [DEPTH];
  level_t           nxt   [DEPTH];
  level_t           nb_up [DEPTH];
  level_t           nb_dn [DEPTH];

  // Compare flags are sampled when the item is accepted and held for the update that follows.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      match_r <= eq_v;
      beats_r <= is_ask ? lt_v : gt_v;
    end
  end

  always_comb begin
    room        = cnt_r < CNT_W'(DEPTH);
    tail        = DEPTH'(1) << cnt_r;
    m_first     = match_r & (~match_r + DEPTH'(1));
    b_first     = beats_r & (~beats_r + DEPTH'(1));
    any_m       = |match_r;
    any_b       = |beats_r;
    ins         = any_b ? b_first : tail;
    load_m      = '0;
    set_m       = '0;
    pull_next_m = '0;
    pull_prev_m = '0;
    cnt_nxt     = cnt_r;
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end else if (ctrl.update) begin
      if (ctrl.replaces) begin
        if (room) begin
          load_m  = tail;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end else if (any_m) begin
        if (item.qty != '0) begin
          set_m = m_first;
        end else begin
          // The matched level is dropped and everything below it moves up by one.
          pull_next_m = ~(m_first - DEPTH'(1));
          cnt_nxt     = cnt_r - CNT_W'(1);
        end
      end else if ((item.qty != '0) && (any_b || room)) begin
        load_m      = ins;
        pull_prev_m = ~(ins | (ins - DEPTH'(1)));
        cnt_nxt     = (room ? cnt_r : CNT_W'(DEPTH - 1)) + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t cctrl;

    if (i == DEPTH - 1) begin : g_last
      assign nb_dn[i] = cur[i];
    end else begin : g_mid
      assign nb_dn[i] = cur[i+1];
    end
    if (i == 0) begin : g_first
      assign nb_up[i] = cur[i];
    end else begin : g_rest
      assign nb_up[i] = cur[i-1];
    end

    assign valid_v[i]      = CNT_W'(i) < cnt_r;
    assign cctrl.load      = load_m[i];
    assign cctrl.set_qty   = set_m[i];
    assign cctrl.pull_next = pull_next_m[i];
    assign cctrl.pull_prev = pull_prev_m[i];

    plbu_cell u_cell (
      .clk        (clk),
      .ctrl       (cctrl),
      .valid      (valid_v[i]),
      .cmp_price  (cmp_price),
      .new_level  (item),
      .prev_level (nb_up[i]),
      .next_level (nb_dn[i]),
      .level      (cur[i]),
      .level_nxt  (nxt[i]),
      .eq         (eq_v[i]),
      .lt         (lt_v[i]),
      .gt         (gt_v[i])
    );
  end

  assign top_nxt = nxt[0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("level count beyond depth");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({|load_m, |set_m, |pull_next_m}))
    else $error("more than one kind of level update in a cycle");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> (cnt_r == '0))
    else $error("side not empty after clear");

endmodule

/* src/price_level_book_update_top.sv */
// Top level of the price level book update block: message handling, the two
// side rows and the result register. Depends on plbu_pkg, the two channel
// interfaces and plbu_row.

// Each input transfer carries one price level of a market data message. In
// the accepting cycle every cell of the addressed side compares its held price
// with the incoming one in parallel, and in the update state that follows the
// row applies the update, delete or insert, every cell taking either the new
// level or the level of its neighbour. The input is ready again only once the
// update is done, so a new level is not taken before the last one is applied;
// the registered compare flags lie between the compare and the shift. The last
// level of a message returns the top of book, the level counts and the update
// id through an output register; a further last level waits in the update
// state only while an earlier result has not yet been taken. The first level
// of a message decides whether the message replaces the whole book (a
// snapshot, or a gap in the update ids) or is applied as deltas. The level
// stores need no clearing after reset, as only levels below the counts are
// ever read.
module price_level_book_update_top import plbu_pkg::*; #(
  parameter int DEPTH = PLBU_DEPTH
) (
  input logic              clk,
  input logic              rst_n,
  plbu_in_if.sink          in_ch,
  plbu_out_if.source       out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic               in_msg_r, in_msg_nxt;
  logic               replaces_r, replaces_nxt;
  logic [ID_W-1:0]    last_id_r, last_id_nxt;
  logic               item_side_r, item_last_r;
  level_t             item_r;
  logic               in_fire, out_fire, gap, clear, upd_done, res_load;
  row_ctrl_t          bid_ctrl, ask_ctrl;
  level_t             bid_top, ask_top;
  logic [CNT_W-1:0]   bid_cnt_nxt, ask_cnt_nxt;
  logic               out_valid_r;
  logic [PRICE_W-1:0] bid_price_r, ask_price_r;
  logic [QTY_W-1:0]   bid_qty_r, ask_qty_r;
  logic [LEVELS_W-1:0] bid_levels_r, ask_levels_r;
  logic [ID_W-1:0]    applied_id_r;
  logic               resynced_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // A last level must not overwrite a result that is still waiting.
  assign upd_done = !(item_last_r && out_valid_r && !out_ch.ready);
  assign res_load = (state_r == ST_UPD) && upd_done && item_last_r;

  // Message start: decide between a full replacement and deltas.
  always_comb begin
    gap          = ((last_id_r + ID_W'(1)) != in_ch.update_id) && (last_id_r != ID_NO_GAP);
    replaces_nxt = replaces_r;
    last_id_nxt  = last_id_r;
    in_msg_nxt   = in_msg_r;
    clear        = 1'b0;
    if (in_fire) begin
      if (!in_msg_r) begin
        replaces_nxt = (in_ch.kind == KIND_SNAPSHOT) || gap;
        clear        = replaces_nxt;
        last_id_nxt  = in_ch.update_id;
      end
      in_msg_nxt = !in_ch.last_of_message;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_msg_r   <= 1'b0;
      replaces_r <= 1'b0;
      last_id_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      in_msg_r   <= in_msg_nxt;
      replaces_r <= replaces_nxt;
      last_id_r  <= last_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_side_r  <= in_ch.book_side;
      item_last_r  <= in_ch.last_of_message;
      item_r.price <= in_ch.price;
      item_r.qty   <= in_ch.quantity;
    end
  end

  always_comb begin
    bid_ctrl.capture  = in_fire;
    bid_ctrl.clear    = clear;
    bid_ctrl.update   = (state_r == ST_UPD) && upd_done && (item_side_r == SIDE_BID);
    bid_ctrl.replaces = replaces_r;
    ask_ctrl          = bid_ctrl;
    ask_ctrl.update   = (state_r == ST_UPD) && upd_done && (item_side_r == SIDE_ASK);
  end

  plbu_row #(.DEPTH(DEPTH)) u_bid_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_ask    (SIDE_BID),
    .ctrl      (bid_ctrl),
    .cmp_price (in_ch.price),
    .item      (item_r),
    .top_nxt   (bid_top),
    .cnt_nxt   (bid_cnt_nxt)
  );

  plbu_row #(.DEPTH(DEPTH)) u_ask_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .is_ask    (SIDE_ASK),
    .ctrl      (ask_ctrl),
    .cmp_price (in_ch.price),
    .item      (item_r),
    .top_nxt   (ask_top),
    .cnt_nxt   (ask_cnt_nxt)
  );

  // Result register: loaded from the book as it stands after the last level.
  // The update id is held here too, as the next message may start while the
  // result is still waiting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      bid_price_r  <= (bid_cnt_nxt != '0) ? bid_top.price : '0;
      bid_qty_r    <= (bid_cnt_nxt != '0) ? bid_top.qty : '0;
      ask_price_r  <= (ask_cnt_nxt != '0) ? ask_top.price : '0;
      ask_qty_r    <= (ask_cnt_nxt != '0) ? ask_top.qty : '0;
      bid_levels_r <= LEVELS_W'(bid_cnt_nxt);
      ask_levels_r <= LEVELS_W'(ask_cnt_nxt);
      applied_id_r <= last_id_r;
      resynced_r   <= replaces_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.best_bid_price = bid_price_r;
  assign out_ch.best_bid_qty   = bid_qty_r;
  assign out_ch.best_ask_price = ask_price_r;
  assign out_ch.best_ask_qty   = ask_qty_r;
  assign out_ch.bid_levels     = bid_levels_r;
  assign out_ch.ask_levels     = ask_levels_r;
  assign out_ch.applied_id     = applied_id_r;
  assign out_ch.resynced       = resynced_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid_r)
    else $error("last level finished without a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !res_load)
    else $error("waiting result overwritten");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(bid_ctrl.update && ask_ctrl.update))
    else $error("both sides updated by one level");

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clear |-> (state_r == ST_IDLE) && !in_msg_r)
    else $error("book cleared inside a message");

endmodule

/* tb/price_level_book_update_top_tb.sv */
// Testbench for price_level_book_update_top: drives market data levels, keeps its own book
// and checks every top of book result field by field. Depends on plbu_pkg, the plbu_in_if
// and plbu_out_if channel interfaces and the block itself.
`timescale 1ns / 1ps

module price_level_book_update_top_tb;
  import plbu_pkg::*;

  localparam int BOOK_DEPTH = PLBU_DEPTH;
  localparam int RANDOM_LEVELS = 600;

  // One price level as the sender offers it.
  typedef struct packed {
    logic               kind;
    logic               book_side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [ID_W-1:0]    update_id;
    logic               last_of_message;
  } level_item_t;

  // Top of book as returned at the end of a message.
  typedef struct packed {
    logic [PRICE_W-1:0]  best_bid_price;
    logic [QTY_W-1:0]    best_bid_qty;
    logic [PRICE_W-1:0]  best_ask_price;
    logic [QTY_W-1:0]    best_ask_qty;
    logic [LEVELS_W-1:0] bid_levels;
    logic [LEVELS_W-1:0] ask_levels;
    logic [ID_W-1:0]     applied_id;
    logic                resynced;
  } top_of_book_t;

  logic clk = 1'b0;
  logic rst_n;

  plbu_in_if  in_ch ();
  plbu_out_if out_ch ();

  price_level_book_update_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Levels still to be offered, and top of book results still to come back.
  level_item_t  level_q[$];
  top_of_book_t top_of_book_q[$];

  int levels_sent  = 0;
  int total_levels = 0;
  int results_seen = 0;
  int err_count    = 0;

  // The testbench's own copy of the book, kept at the block's widths.
  logic [PRICE_W-1:0] lvl_px  [2][BOOK_DEPTH];
  logic [QTY_W-1:0]   lvl_qty [2][BOOK_DEPTH];
  int                 lvl_cnt [2];
  logic [ID_W-1:0]    book_last_id = '0;
  logic               msg_open = 1'b0;
  logic               msg_full = 1'b0;

  // Sender and receiver pacing.
  int   idle_left   = 0;
  int   burst_left  = 0;
  int   window_left = 0;
  int   ready_pct   = 100;
  logic hold_off    = 1'b0;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 50) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  function automatic void append_level(input logic side, input logic [PRICE_W-1:0] px,
                                       input logic [QTY_W-1:0] qty);
    if (lvl_cnt[side] < BOOK_DEPTH) begin
      lvl_px[side][lvl_cnt[side]]  = px;
      lvl_qty[side][lvl_cnt[side]] = qty;
      lvl_cnt[side]++;
    end
  endfunction

  // A delta level: replace or delete the first level held at this price, otherwise
  // insert it ahead of the first level it beats, trimming the side to its depth.
  function automatic void apply_delta(input logic side, input logic [PRICE_W-1:0] px,
                                      input logic [QTY_W-1:0] qty);
    int n;
    int hit;
    int pos;
    int keep;
    n   = lvl_cnt[side];
    hit = -1;
    pos = n;
    for (int i = 0; i < n; i++) begin
      if (hit < 0 && lvl_px[side][i] == px) hit = i;
    end
    if (hit >= 0) begin
      if (qty != '0) begin
        lvl_qty[side][hit] = qty;
      end else begin
        for (int i = hit; i < n - 1; i++) begin
          lvl_px[side][i]  = lvl_px[side][i + 1];
          lvl_qty[side][i] = lvl_qty[side][i + 1];
        end
        lvl_cnt[side] = n - 1;
      end
    end else if (qty != '0) begin
      // Walking upwards leaves pos at the first level that the new price beats.
      for (int i = n - 1; i >= 0; i--) begin
        if ((side == SIDE_ASK) ? (px < lvl_px[side][i]) : (px > lvl_px[side][i])) pos = i;
      end
      if (pos < BOOK_DEPTH) begin
        keep = (n < BOOK_DEPTH) ? n : BOOK_DEPTH - 1;
        for (int i = keep; i > pos; i--) begin
          lvl_px[side][i]  = lvl_px[side][i - 1];
          lvl_qty[side][i] = lvl_qty[side][i - 1];
        end
        lvl_px[side][pos]  = px;
        lvl_qty[side][pos] = qty;
        lvl_cnt[side]      = keep + 1;
      end
    end
  endfunction

  // Applies one accepted level to the book and, on the last level of a message,
  // records the top of book that the block must return.
  function automatic void apply_level(input level_item_t lv);
    logic [ID_W-1:0] next_id;
    top_of_book_t    tob;
    if (!msg_open) begin
      next_id  = book_last_id + 1'b1;
      msg_full = (lv.kind == KIND_SNAPSHOT) ||
                 ((next_id != lv.update_id) && (book_last_id != ID_NO_GAP));
      if (msg_full) begin
        lvl_cnt[SIDE_BID] = 0;
        lvl_cnt[SIDE_ASK] = 0;
      end
      book_last_id = lv.update_id;
      msg_open     = 1'b1;
    end
    if (msg_full) begin
      append_level(lv.book_side, lv.price, lv.quantity);
    end else begin
      apply_delta(lv.book_side, lv.price, lv.quantity);
    end
    if (lv.last_of_message) begin
      msg_open = 1'b0;
      tob.best_bid_price = (lvl_cnt[SIDE_BID] != 0) ? lvl_px[SIDE_BID][0] : '0;
      tob.best_bid_qty   = (lvl_cnt[SIDE_BID] != 0) ? lvl_qty[SIDE_BID][0] : '0;
      tob.best_ask_price = (lvl_cnt[SIDE_ASK] != 0) ? lvl_px[SIDE_ASK][0] : '0;
      tob.best_ask_qty   = (lvl_cnt[SIDE_ASK] != 0) ? lvl_qty[SIDE_ASK][0] : '0;
      tob.bid_levels     = LEVELS_W'(lvl_cnt[SIDE_BID]);
      tob.ask_levels     = LEVELS_W'(lvl_cnt[SIDE_ASK]);
      tob.applied_id     = book_last_id;
      tob.resynced       = msg_full;
      top_of_book_q.push_back(tob);
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  function automatic void push_level(input logic kind, input logic side,
                                     input logic [PRICE_W-1:0] px,
                                     input logic [QTY_W-1:0] qty,
                                     input logic [ID_W-1:0] id, input logic last);
    level_item_t lv;
    lv.kind            = kind;
    lv.book_side       = side;
    lv.price           = px;
    lv.quantity        = qty;
    lv.update_id       = id;
    lv.last_of_message = last;
    level_q.push_back(lv);
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Quantities: deltas delete fairly often, otherwise small or full range values.
  function automatic logic [QTY_W-1:0] pick_qty(input logic kind);
    if ($urandom_range(0, 99) < ((kind == KIND_DELTA) ? 25 : 5)) return '0;
    if ($urandom_range(0, 1) == 0) return QTY_W'($urandom_range(1, 1000));
    return QTY_W'($urandom);
  endfunction

  // Prices cluster round a centre so that deltas often hit levels already held.
  function automatic logic [PRICE_W-1:0] pick_price(input logic side,
                                                    input logic [PRICE_W-1:0] centre);
    if ($urandom_range(0, 99) < 12) return PRICE_W'($urandom);
    if (side == SIDE_BID) return centre - PRICE_W'($urandom_range(0, 40));
    return centre + PRICE_W'($urandom_range(0, 40));
  endfunction

  // Stimulus. The queue is filled at time zero, before reset is released, so
  // the driver below only ever consumes it.
  initial begin
    logic [ID_W-1:0]    next_msg_id;
    logic [ID_W-1:0]    msg_id;
    logic [ID_W-1:0]    lvl_id;
    logic [PRICE_W-1:0] price_centre;
    logic [PRICE_W-1:0] bid_px;
    logic [PRICE_W-1:0] ask_px;
    logic [PRICE_W-1:0] px;
    logic               msg_kind;
    logic               lvl_kind;
    logic               side;
    logic               sorted;
    int                 n_levels;
    int                 n_directed;
    int                 r;

    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.kind             = KIND_SNAPSHOT;
    in_ch.book_side        = SIDE_BID;
    in_ch.price            = '0;
    in_ch.quantity         = '0;
    in_ch.update_id        = '0;
    in_ch.last_of_message  = 1'b0;
    out_ch.ready           = 1'b0;
    lvl_cnt[SIDE_BID]      = 0;
    lvl_cnt[SIDE_ASK]      = 0;

    // A snapshot with two bids and three asks, one of them carrying zero quantity,
    // which a replacement keeps as given.
    push_level(KIND_SNAPSHOT, SIDE_BID, 32'd1000, 32'd10, 48'd100, 1'b0);
    push_level(KIND_SNAPSHOT, SIDE_BID, 32'd990,  32'd20, 48'd100, 1'b0);
    push_level(KIND_SNAPSHOT, SIDE_ASK, 32'd1010, 32'd5,  48'd100, 1'b0);
    push_level(KIND_SNAPSHOT, SIDE_ASK, 32'd1020, 32'd0,  48'd100, 1'b0);
    push_level(KIND_SNAPSHOT, SIDE_ASK, 32'd1030, 32'd7,  48'd100, 1'b1);
    // Deltas in sequence: insert in the middle, delete the top bid, replace a
    // quantity, a new best ask, and a zero quantity on an absent price.
    push_level(KIND_DELTA, SIDE_BID, 32'd995,  32'd3, 48'd101, 1'b0);
    push_level(KIND_DELTA, SIDE_BID, 32'd1000, 32'd0, 48'd101, 1'b0);
    push_level(KIND_DELTA, SIDE_ASK, 32'd1020, 32'd9, 48'd101, 1'b0);
    push_level(KIND_DELTA, SIDE_ASK, 32'd1005, 32'd1, 48'd101, 1'b0);
    push_level(KIND_DELTA, SIDE_BID, 32'd1,    32'd0, 48'd101, 1'b1);
    // An id gap turns a delta into a full replacement; the second level's kind
    // and id must be ignored.
    push_level(KIND_DELTA,    SIDE_BID, '1,    '1,    48'd500, 1'b0);
    push_level(KIND_SNAPSHOT, SIDE_ASK, 32'd0, 32'd1, 48'd0,   1'b1);
    // With the stored id at one, any following id is taken without a gap.
    push_level(KIND_SNAPSHOT, SIDE_BID, 32'd5, 32'd5, 48'd1, 1'b1);
    push_level(KIND_DELTA,    SIDE_BID, 32'd6, 32'd2, 48'h0000_1234_5678, 1'b1);
    // The largest id followed by zero: the id wraps and the delta empties the book.
    push_level(KIND_SNAPSHOT, SIDE_ASK, 32'd8, 32'd8, '1,    1'b1);
    push_level(KIND_DELTA,    SIDE_ASK, 32'd8, 32'd0, 48'd0, 1'b1);
    // Deltas into an empty book, one at the extremes of price and quantity.
    push_level(KIND_DELTA, SIDE_BID, 32'd42, 32'd1, 48'd1, 1'b0);
    push_level(KIND_DELTA, SIDE_ASK, '1,     '1,    48'd1, 1'b1);

    n_directed   = level_q.size();
    next_msg_id  = 48'd2;
    price_centre = PRICE_W'($urandom_range(1000, 100000));

    // Random messages: mostly deltas in id sequence, some snapshots (a third of
    // them with 28 to 36 levels, spread over both sides) and some id gaps.
    while (level_q.size() < n_directed + RANDOM_LEVELS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        msg_kind = KIND_SNAPSHOT;
        msg_id   = ($urandom_range(0, 1) == 0) ? next_msg_id : random_id();
      end else if (r < 16) begin
        msg_kind = KIND_DELTA;
        msg_id   = random_id();
      end else begin
        msg_kind = KIND_DELTA;
        msg_id   = next_msg_id;
      end
      if (msg_kind == KIND_SNAPSHOT && $urandom_range(0, 2) == 0) begin
        n_levels = $urandom_range(28, 36);
      end else begin
        n_levels = $urandom_range(1, 6);
      end
      sorted = ($urandom_range(0, 4) != 0);
      bid_px = price_centre;
      ask_px = price_centre + 1'b1;
      for (int k = 0; k < n_levels; k++) begin
        side = 1'($urandom_range(0, 1));
        if (msg_kind == KIND_SNAPSHOT && sorted) begin
          if (side == SIDE_BID) begin
            bid_px = bid_px - PRICE_W'($urandom_range(1, 3));
            px     = bid_px;
          end else begin
            ask_px = ask_px + PRICE_W'($urandom_range(1, 3));
            px     = ask_px;
          end
        end else begin
          px = pick_price(side, price_centre);
        end
        lvl_kind = msg_kind;
        lvl_id   = msg_id;
        // Later levels of a message may carry any kind and id.
        if (k > 0 && $urandom_range(0, 3) == 0) begin
          lvl_kind = 1'($urandom_range(0, 1));
          lvl_id   = random_id();
        end
        push_level(lvl_kind, side, px, pick_qty(msg_kind), lvl_id, k == n_levels - 1);
      end
      next_msg_id = msg_id + 1'b1;
      if ($urandom_range(0, 99) < 3) price_centre = PRICE_W'($urandom);
    end
    total_levels = level_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Every level must have been transferred and every result returned before the drain.
    while (levels_sent != total_levels) @(posedge clk);
    while (top_of_book_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (top_of_book_q.size() != 0) begin
      report_mismatch("expected result never returned");
    end
    if (err_count == 0) begin
      $display("PASS price_level_book_update_top");
    end else begin
      $display("FAIL price_level_book_update_top");
    end
    $finish;
  end

  // Sender: bursts of random length separated by random gaps. A level being
  // offered stays on the channel until its transfer, and each accepted level is
  // applied to the book at the edge of its transfer.
  always @(posedge clk) begin
    logic offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_level(level_q.pop_front());
        levels_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        offer = 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
      end else if (level_q.size() > 0) begin
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Now and then a long burst, so that stretches run with no gaps at all.
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 10);
          idle_left  = $urandom_range(1, 6);
        end
      end
      in_ch.valid <= offer;
      if (offer) begin
        in_ch.kind            <= level_q[0].kind;
        in_ch.book_side       <= level_q[0].book_side;
        in_ch.price           <= level_q[0].price;
        in_ch.quantity        <= level_q[0].quantity;
        in_ch.update_id       <= level_q[0].update_id;
        in_ch.last_of_message <= level_q[0].last_of_message;
      end
    end
  end

  // Receiver: ready is drawn each cycle with a probability that changes from
  // one window of cycles to the next, from always ready down to mostly stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (window_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 35;
          default: ready_pct = 10;
        endcase
        window_left = $urandom_range(8, 64);
      end else begin
        window_left--;
      end
      out_ch.ready <= !hold_off && ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // One long hold-off on the result side once traffic is flowing: the sender
  // carries on, so the output register fills, a further last level waits in
  // the block and the input stops accepting.
  initial begin
    while (results_seen < 30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Monitor: each result transfer is checked against the oldest expected top
  // of book.
  always @(posedge clk) begin
    top_of_book_t got;
    top_of_book_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got.best_bid_price = out_ch.best_bid_price;
      got.best_bid_qty   = out_ch.best_bid_qty;
      got.best_ask_price = out_ch.best_ask_price;
      got.best_ask_qty   = out_ch.best_ask_qty;
      got.bid_levels     = out_ch.bid_levels;
      got.ask_levels     = out_ch.ask_levels;
      got.applied_id     = out_ch.applied_id;
      got.resynced       = out_ch.resynced;
      if (top_of_book_q.size() == 0) begin
        report_mismatch("result transfer with no expected result");
      end else begin
        want = top_of_book_q.pop_front();
        check_field("best_bid_price", got.best_bid_price, want.best_bid_price);
        check_field("best_bid_qty",   got.best_bid_qty,   want.best_bid_qty);
        check_field("best_ask_price", got.best_ask_price, want.best_ask_price);
        check_field("best_ask_qty",   got.best_ask_qty,   want.best_ask_qty);
        check_field("bid_levels",     got.bid_levels,     want.bid_levels);
        check_field("ask_levels",     got.ask_levels,     want.ask_levels);
        check_field("applied_id",     got.applied_id,     want.applied_id);
        check_field("resynced",       got.resynced,       want.resynced);
      end
    end
  end

  // Overall limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL price_level_book_update_top");
    $finish;
  end

endmodule
